// File: src/lpr_pkg.sv
`default_nettype none

package lpr_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_RESOLVE,
    PH_SET,
    PH_SKIP
  } phase_t;

  typedef enum logic [1:0] {
    SCAN_CLIMB_SLASH,
    SCAN_CLIMB_NAME,
    SCAN_STRIP_WORK,
    SCAN_STRIP_DIR
  } scan_mode_t;

endpackage

`default_nettype wire

// File: src/lexical_path_resolver_unit.sv
`default_nettype none

// Lexical path resolver. Path strings arrive one byte per transaction on the
// s_ side (tdata = character, tuser = op: 0 resolve, 1 set working directory),
// each string ended by a zero byte. A set-directory string must start with
// '/'; it is cut to PATH_BYTES-1 bytes and stripped of trailing slashes. A
// resolve string starts at root when absolute, else from a copy of the
// working directory; '.' is dropped, '..' pops one component (never above
// root), and the result is clipped to cfg capacity-1 bytes. The zero byte of a
// resolve string yields the resolved path on the m_ side, one byte per
// transaction, tlast on its final byte. An ordinary byte passes through the
// processing states; the first byte of a relative path first copies the
// directory into the work buffer; '..' and the final strip walk back through
// the work buffer one byte at a time; each output byte is read, then shown
// and held until m_tready. This pace comes from the single read port of
// each buffer RAM, whose read is registered. Inputs are taken only between
// these operations.
module lexical_path_resolver_unit #(
  parameter int PATH_BYTES = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [6:0] cfg_data,     // out_capacity
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,      // ch
  input  wire logic       s_tuser,      // op
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic      [7:0] m_tdata,      // out_char
  output logic            m_tlast       // last
);

  import lpr_pkg::*;

  localparam int AW = $clog2(PATH_BYTES);
  localparam int CW = 10;
  localparam logic [CW-1:0] PB_W = CW'(PATH_BYTES);
  localparam logic [AW-1:0] DIR_MAX = AW'(PATH_BYTES - 1);
  localparam logic [AW-1:0] ONE = AW'(1);

  typedef enum logic [3:0] {
    S_IN,
    S_COPY,
    S_PROC,
    S_SEGW,
    S_SCAN,
    S_SCANW,
    S_EMITR,
    S_EMITW,
    S_EMITH
  } state_t;

  state_t     state, state_next;
  phase_t     phase, phase_next;
  scan_mode_t mode, mode_next;
  logic [6:0] cap;
  logic       dir_init, dir_init_next;
  logic [AW-1:0] dl, dl_next, wl, wl_next, rb, rb_next, sn, sn_next;
  logic [AW-1:0] cnt, cnt_next, cp_n, cp_n_next, cp_wa, cp_wa_next, ei, ei_next;
  logic       cp_pend, cp_pend_next;
  logic [7:0] hc, hc_next;
  logic [1:0] seg, seg_next;
  logic       dot0, dot0_next, dot1, dot1_next;
  logic       m_tvalid_next, m_tlast_next;
  logic [7:0] m_tdata_next;

  logic          dw_en, ww_en;
  logic [AW-1:0] dw_addr, dr_addr, ww_addr, wr_addr;
  logic [7:0]    dw_data, ww_data, dir_q, work_q, dir_d, scan_d;

  logic [CW-1:0] cap_w;
  logic [AW-1:0] lim;
  logic          s_acc;
  logic [AW-1:0] wl_fin;

  lpr_ram #(.WIDTH(8), .DEPTH(PATH_BYTES)) u_dir (
    .clk(clk), .we(dw_en), .waddr(dw_addr), .wdata(dw_data),
    .raddr(dr_addr), .rdata(dir_q)
  );

  lpr_ram #(.WIDTH(8), .DEPTH(PATH_BYTES)) u_work (
    .clk(clk), .we(ww_en), .waddr(ww_addr), .wdata(ww_data),
    .raddr(wr_addr), .rdata(work_q)
  );

  // Clamp capacity to 2..PATH_BYTES; room is one less
  assign cap_w = CW'(cap);
  always_comb begin
    if (cap_w < CW'(2)) begin
      lim = ONE;
    end else if (cap_w > PB_W) begin
      lim = DIR_MAX;
    end else begin
      lim = AW'(cap_w - CW'(1));
    end
  end

  // Entry zero of the directory reads as root until the first set-directory
  assign dir_d  = dir_init ? CH_SLASH : dir_q;
  assign scan_d = (mode == SCAN_STRIP_DIR) ? dir_d : work_q;
  assign s_tready = (state == S_IN);
  assign s_acc = s_tvalid && s_tready;

  always_comb begin
    state_next    = state;
    phase_next    = phase;
    mode_next     = mode;
    dir_init_next = dir_init;
    dl_next       = dl;
    wl_next       = wl;
    rb_next       = rb;
    sn_next       = sn;
    cnt_next      = cnt;
    cp_n_next     = cp_n;
    cp_wa_next    = cp_wa;
    cp_pend_next  = 1'b0;
    ei_next       = ei;
    hc_next       = hc;
    seg_next      = seg;
    dot0_next     = dot0;
    dot1_next     = dot1;
    m_tvalid_next = m_tvalid;
    m_tdata_next  = m_tdata;
    m_tlast_next  = m_tlast;
    dw_en   = 1'b0;
    dw_addr = dl;
    dw_data = s_tdata;
    dr_addr = cnt;
    ww_en   = 1'b0;
    ww_addr = wl;
    ww_data = hc;
    wr_addr = ei;
    wl_fin  = wl;

    case (state)
      S_IN: begin
        if (s_acc) begin
          case (phase)
            PH_IDLE: begin
              if (s_tuser) begin
                if (s_tdata != CH_SLASH) begin
                  phase_next = (s_tdata == CH_NUL) ? PH_IDLE : PH_SKIP;
                end else begin
                  dw_en = 1'b1;
                  dw_addr = '0;
                  dw_data = CH_SLASH;
                  dir_init_next = 1'b0;
                  dl_next = ONE;
                  phase_next = PH_SET;
                end
              end else begin
                seg_next = '0;
                dot0_next = 1'b0;
                dot1_next = 1'b0;
                phase_next = PH_RESOLVE;
                if (s_tdata == CH_SLASH) begin
                  ww_en = 1'b1;
                  ww_addr = '0;
                  ww_data = CH_SLASH;
                  wl_next = ONE;
                end else begin
                  // Relative start: copy the directory, clipped to the room
                  hc_next = s_tdata;
                  cp_n_next = (dl < lim) ? dl : lim;
                  cnt_next = '0;
                  state_next = S_COPY;
                end
              end
            end
            PH_SKIP: begin
              if (s_tdata == CH_NUL) begin
                phase_next = PH_IDLE;
              end
            end
            PH_SET: begin
              if (s_tdata == CH_NUL) begin
                sn_next = dl;
                mode_next = SCAN_STRIP_DIR;
                state_next = S_SCAN;
              end else if (dl < DIR_MAX) begin
                dw_en = 1'b1;
                dw_addr = dl;
                dl_next = dl + ONE;
              end
            end
            default: begin
              hc_next = s_tdata;
              state_next = S_PROC;
            end
          endcase
        end
      end

      S_COPY: begin
        // Read one ahead, write the byte read last cycle
        dr_addr = cnt;
        if (cnt < cp_n) begin
          cp_pend_next = 1'b1;
          cp_wa_next = cnt;
          cnt_next = cnt + ONE;
        end
        if (cp_pend) begin
          ww_en = 1'b1;
          ww_addr = cp_wa;
          ww_data = dir_d;
        end
        if (cnt == cp_n && !cp_pend) begin
          wl_next = cp_n;
          state_next = S_PROC;
        end
      end

      S_PROC: begin
        if (hc != CH_NUL && hc != CH_SLASH) begin
          if (seg == 2'd0) begin
            rb_next = wl;
            if (wl > ONE && wl < lim) begin
              ww_en = 1'b1;
              ww_addr = wl;
              ww_data = CH_SLASH;
              wl_next = wl + ONE;
            end
          end
          state_next = S_SEGW;
        end else begin
          seg_next = '0;
          dot0_next = 1'b0;
          dot1_next = 1'b0;
          if (seg == 2'd1 && dot0) begin
            wl_fin = rb;
          end
          wl_next = wl_fin;
          if (seg == 2'd2 && dot0 && dot1) begin
            sn_next = rb;
            mode_next = SCAN_CLIMB_SLASH;
            state_next = S_SCAN;
          end else if (hc == CH_NUL) begin
            sn_next = wl_fin;
            mode_next = SCAN_STRIP_WORK;
            state_next = S_SCAN;
          end else begin
            state_next = S_IN;
          end
        end
      end

      S_SEGW: begin
        if (wl < lim) begin
          ww_en = 1'b1;
          ww_addr = wl;
          ww_data = hc;
          wl_next = wl + ONE;
        end
        if (seg == 2'd0) begin
          dot0_next = (hc == CH_DOT);
        end
        if (seg == 2'd1) begin
          dot1_next = (hc == CH_DOT);
        end
        if (seg != 2'd3) begin
          seg_next = seg + 2'd1;
        end
        state_next = S_IN;
      end

      S_SCAN: begin
        dr_addr = sn - ONE;
        wr_addr = sn - ONE;
        if (sn > ONE) begin
          state_next = S_SCANW;
        end else begin
          case (mode)
            SCAN_STRIP_DIR: begin
              dl_next = sn;
              phase_next = PH_IDLE;
              state_next = S_IN;
            end
            SCAN_STRIP_WORK: begin
              if (sn == '0) begin
                ww_en = 1'b1;
                ww_addr = '0;
                ww_data = CH_SLASH;
                wl_next = ONE;
              end else begin
                wl_next = sn;
              end
              ei_next = '0;
              phase_next = PH_IDLE;
              state_next = S_EMITR;
            end
            default: begin
              // Climbed to root
              ww_en = 1'b1;
              ww_addr = '0;
              ww_data = CH_SLASH;
              wl_next = ONE;
              sn_next = ONE;
              mode_next = SCAN_STRIP_WORK;
              state_next = (hc == CH_NUL) ? S_SCAN : S_IN;
            end
          endcase
        end
      end

      S_SCANW: begin
        state_next = S_SCAN;
        case (mode)
          SCAN_CLIMB_NAME: begin
            if (scan_d != CH_SLASH) begin
              sn_next = sn - ONE;
            end else begin
              wl_next = sn - ONE;
              sn_next = sn - ONE;
              mode_next = SCAN_STRIP_WORK;
              state_next = (hc == CH_NUL) ? S_SCAN : S_IN;
            end
          end
          default: begin
            if (scan_d == CH_SLASH) begin
              sn_next = sn - ONE;
            end else if (mode == SCAN_CLIMB_SLASH) begin
              mode_next = SCAN_CLIMB_NAME;
            end else if (mode == SCAN_STRIP_DIR) begin
              dl_next = sn;
              phase_next = PH_IDLE;
              state_next = S_IN;
            end else begin
              wl_next = sn;
              ei_next = '0;
              phase_next = PH_IDLE;
              state_next = S_EMITR;
            end
          end
        endcase
      end

      S_EMITR: begin
        wr_addr = ei;
        state_next = S_EMITW;
      end

      S_EMITW: begin
        m_tvalid_next = 1'b1;
        m_tdata_next = work_q;
        m_tlast_next = (ei == wl - ONE);
        state_next = S_EMITH;
      end

      S_EMITH: begin
        if (m_tready) begin
          m_tvalid_next = 1'b0;
          if (m_tlast) begin
            state_next = S_IN;
          end else begin
            ei_next = ei + ONE;
            state_next = S_EMITR;
          end
        end
      end

      default: begin
        state_next = S_IN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IN;
      phase    <= PH_IDLE;
      mode     <= SCAN_STRIP_WORK;
      cap      <= CAP_RESET;
      dir_init <= 1'b1;
      dl       <= ONE;
      wl       <= '0;
      rb       <= '0;
      seg      <= '0;
      dot0     <= 1'b0;
      dot1     <= 1'b0;
      cp_pend  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      mode     <= mode_next;
      if (cfg_we) begin
        cap <= cfg_data;
      end
      dir_init <= dir_init_next;
      dl       <= dl_next;
      wl       <= wl_next;
      rb       <= rb_next;
      seg      <= seg_next;
      dot0     <= dot0_next;
      dot1     <= dot1_next;
      cp_pend  <= cp_pend_next;
      m_tvalid <= m_tvalid_next;
    end
    sn      <= sn_next;
    cnt     <= cnt_next;
    cp_n    <= cp_n_next;
    cp_wa   <= cp_wa_next;
    ei      <= ei_next;
    hc      <= hc_next;
    m_tdata <= m_tdata_next;
    m_tlast <= m_tlast_next;
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input taken while a result is pending");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (s_tready && phase == PH_IDLE))
    else $error("final result byte did not return to idle");

  a_valid_state: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (state == S_EMITH))
    else $error("result shown outside the emit hold");

  a_copy_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_COPY) |-> (cp_n != '0))
    else $error("empty directory copy");

endmodule

`default_nettype wire

// File: src/lpr_ram.sv
`default_nettype none

module lpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: dv/lpr_checker.sv
`timescale 1ns / 100ps

module lpr_checker #(
  parameter int PATH_BYTES = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [6:0] cfg_data,
  input  wire logic       s_tvalid,
  input  wire logic       s_tready,
  input  wire logic [7:0] s_tdata,
  input  wire logic       s_tuser,
  input  wire logic       m_tvalid,
  input  wire logic       m_tready,
  input  wire logic [7:0] m_tdata,
  input  wire logic       m_tlast,
  output int              fail_count,
  output int              pending,
  output int              paths_seen
);
  import lpr_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } path_byte_t;

  logic [6:0] capacity;
  logic [7:0] dir_buf [PATH_BYTES];
  int         dir_len;
  logic [7:0] work_buf [PATH_BYTES];
  int         work_len;
  int         seg_len;
  logic [7:0] seg_c0, seg_c1;
  int         rollback;
  phase_t     phase;
  path_byte_t resolved_q [$];

  assign pending = resolved_q.size();

  function automatic int room();
    int cap;
    cap = capacity;
    if (cap < 2) cap = 2;
    if (cap > PATH_BYTES) cap = PATH_BYTES;
    return cap - 1;
  endfunction

  function automatic void pop_component();
    int n;
    n = work_len;
    while (n > 1 && work_buf[n-1] == CH_SLASH) n--;
    while (n > 1 && work_buf[n-1] != CH_SLASH) n--;
    if (n <= 1) begin
      work_buf[0] = CH_SLASH;
      work_len = 1;
    end else begin
      work_len = n - 1;
    end
  endfunction

  function automatic void close_component();
    if (seg_len == 1 && seg_c0 == CH_DOT) begin
      work_len = rollback;
    end else if (seg_len == 2 && seg_c0 == CH_DOT && seg_c1 == CH_DOT) begin
      work_len = rollback;
      pop_component();
    end
    seg_len = 0;
    seg_c0 = 8'h00;
    seg_c1 = 8'h00;
  endfunction

  function automatic void add_byte(logic [7:0] c);
    int lim;
    lim = room();
    if (seg_len == 0) begin
      rollback = work_len;
      if (work_len > 1 && work_len < lim) begin
        work_buf[work_len] = CH_SLASH;
        work_len++;
      end
    end
    if (work_len < lim) begin
      work_buf[work_len] = c;
      work_len++;
    end
    if (seg_len == 0) seg_c0 = c;
    else if (seg_len == 1) seg_c1 = c;
    if (seg_len < 255) seg_len++;
  endfunction

  // Advance the model by one input byte; queue the path on a resolve terminator.
  function automatic void take_byte(logic op, logic [7:0] c);
    int n;
    path_byte_t pb;
    if (phase == PH_SKIP) begin
      if (c == CH_NUL) phase = PH_IDLE;
      return;
    end
    if (phase == PH_SET) begin
      if (c == CH_NUL) begin
        while (dir_len > 1 && dir_buf[dir_len-1] == CH_SLASH) dir_len--;
        phase = PH_IDLE;
      end else if (dir_len < PATH_BYTES - 1) begin
        dir_buf[dir_len] = c;
        dir_len++;
      end
      return;
    end
    if (phase == PH_IDLE) begin
      if (op) begin
        if (c != CH_SLASH) begin
          phase = (c == CH_NUL) ? PH_IDLE : PH_SKIP;
          return;
        end
        dir_buf[0] = c;
        dir_len = 1;
        phase = PH_SET;
        return;
      end
      seg_len = 0;
      seg_c0 = 8'h00;
      seg_c1 = 8'h00;
      phase = PH_RESOLVE;
      if (c == CH_SLASH) begin
        work_buf[0] = CH_SLASH;
        work_len = 1;
        return;
      end
      n = (dir_len < room()) ? dir_len : room();
      for (int i = 0; i < n; i++) work_buf[i] = dir_buf[i];
      work_len = n;
    end
    if (c != CH_NUL && c != CH_SLASH) begin
      add_byte(c);
      return;
    end
    if (seg_len > 0) close_component();
    if (c != CH_NUL) return;
    while (work_len > 1 && work_buf[work_len-1] == CH_SLASH) work_len--;
    if (work_len == 0) begin
      work_buf[0] = CH_SLASH;
      work_len = 1;
    end
    phase = PH_IDLE;
    for (int i = 0; i < work_len; i++) begin
      pb.ch = work_buf[i];
      pb.last = (i + 1 == work_len);
      resolved_q.push_back(pb);
    end
  endfunction

  always @(posedge clk) begin
    path_byte_t want;
    if (rst) begin
      capacity <= CAP_RESET;
      for (int i = 0; i < PATH_BYTES; i++) dir_buf[i] = 8'h00;
      dir_buf[0] = CH_SLASH;
      dir_len = 1;
      work_len = 0;
      seg_len = 0;
      seg_c0 = 8'h00;
      seg_c1 = 8'h00;
      rollback = 0;
      phase = PH_IDLE;
      resolved_q.delete();
      fail_count <= 0;
      paths_seen <= 0;
    end else begin
      // compare output first: it was produced from earlier input
      if (m_tvalid && m_tready) begin
        if (resolved_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("unexpected output byte %h last %b", m_tdata, m_tlast);
        end else begin
          want = resolved_q.pop_front();
          if (want.ch !== m_tdata || want.last !== m_tlast) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: expected %h/%b got %h/%b",
                       want.ch, want.last, m_tdata, m_tlast);
          end
          if (m_tlast) paths_seen <= paths_seen + 1;
        end
      end
      if (s_tvalid && s_tready) take_byte(s_tuser, s_tdata);
      if (cfg_we) capacity <= cfg_data;
    end
  end
endmodule

// File: dv/tb_lexical_path_resolver_unit.sv
`timescale 1ns / 100ps

module tb_lexical_path_resolver_unit;
  import lpr_pkg::*;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [6:0] cfg_data;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;      // ch
  logic       s_tuser;      // op
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;      // out_char
  logic       m_tlast;      // last
  int         fail_count;
  int         pending;
  int         paths_seen;
  int         src_idle_pct;
  int         sink_stall_pct;
  int         bytes_sent;

  lexical_path_resolver_unit #(.PATH_BYTES(64)) DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  lpr_checker #(.PATH_BYTES(64)) u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .fail_count(fail_count), .pending(pending), .paths_seen(paths_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #20ms;
    $display("tb_lexical_path_resolver_unit: done, errors");
    $finish;
  end

  // Stall the receiver at the rate of the current phase.
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Send one transaction, idling beforehand at the current rate.
  // Valid stays high after the accepting edge; an idle before the next byte, or settle, drops it.
  task automatic send_byte(logic op, logic [7:0] c);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(logic op, string text);
    for (int i = 0; i < text.len(); i++) send_byte(op, text[i]);
    send_byte(op, CH_NUL);
  endtask

  // Let trailing work settle, then drain all expected output before a write.
  task automatic settle();
    s_tvalid <= 1'b0;
    repeat (300) @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_capacity(logic [6:0] cap);
    settle();
    cfg_we <= 1'b1;
    cfg_data <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random path: components of names, dots, noise bytes and slash runs.
  task automatic send_random_path(logic op);
    int parts;
    int kind;
    if ($urandom_range(99) < 60) send_byte(op, CH_SLASH);
    parts = $urandom_range(6);
    for (int p = 0; p < parts; p++) begin
      kind = $urandom_range(9);
      if (kind < 2) begin
        send_byte(op, CH_DOT);
      end else if (kind < 4) begin
        send_byte(op, CH_DOT);
        send_byte(op, CH_DOT);
      end else if (kind == 4) begin
        // noise: any nonzero byte, op flips mid-string
        repeat ($urandom_range(1, 3)) send_byte(~op, 8'($urandom_range(1, 255)));
      end else begin
        repeat ($urandom_range(1, 9))
          send_byte(1'($urandom_range(1)), 8'($urandom_range(97, 122)));
        if ($urandom_range(9) == 0) send_byte(op, CH_DOT);
      end
      repeat ($urandom_range(1, 2)) send_byte(op, CH_SLASH);
    end
    send_byte(op, CH_NUL);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    bytes_sent = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty, root, dots, climbing past root, set-directory cases
    send_text(1'b0, "");
    send_text(1'b0, "//a/./b/../..//..");
    send_text(1'b0, "x");
    send_text(1'b1, "rel");
    send_text(1'b1, "");
    send_text(1'b1, "/usr/lib//");
    send_text(1'b0, "../b.");
    send_text(1'b0, "...");
    send_byte(1'b0, 8'hFF);
    send_byte(1'b1, 8'h80);
    send_byte(1'b0, CH_NUL);
    write_capacity(7'd2);
    send_text(1'b0, "abc/d");
    write_capacity(7'd0);
    send_text(1'b0, "/q");
    write_capacity(7'd127);
    send_text(1'b0, "k");
    write_capacity(7'd5);
    send_text(1'b0, "zz");

    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 37 : 72) : 0;
      sink_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 37 : 72) : 0;
      write_capacity(7'($urandom_range(127)));
      for (int n = 0; n < 4; n++) begin
        if ($urandom_range(9) == 0) begin
          send_random_path(1'b1);
        end else if ($urandom_range(19) == 0) begin
          // a long component to push past the capacity
          send_byte(1'b0, CH_SLASH);
          repeat (70) send_byte(1'b0, 8'($urandom_range(1, 255)) | 8'h01);
          send_byte(1'b0, CH_NUL);
        end else begin
          send_random_path(1'b0);
        end
      end
      if (ph == 1) write_capacity(7'd64);
    end

    settle();
    $display("covered %0d input bytes and %0d resolved paths", bytes_sent, paths_seen);
    if (fail_count == 0) begin
      $display("tb_lexical_path_resolver_unit: done, clean");
    end else begin
      $display("tb_lexical_path_resolver_unit: done, errors");
    end
    $finish;
  end
endmodule

// File: files.f
src/lpr_pkg.sv
src/lpr_ram.sv
src/lexical_path_resolver_unit.sv
dv/lpr_checker.sv
dv/tb_lexical_path_resolver_unit.sv
